### rtl/dbea_pkg.sv
// ----------------------------------------------------------------------------
// Day bucket energy accumulator package
// Shared widths, reset values and the cell-to-cell bus types.
// ----------------------------------------------------------------------------
package dbea_pkg;

  localparam int unsigned SlotCountDef = 32;
  localparam int unsigned TsW    = 63;
  localparam int unsigned DayW   = 24;
  localparam int unsigned SlotEW = 54;
  localparam int unsigned EnW    = 63;
  localparam int unsigned GapW   = 26;
  localparam int unsigned SpanW  = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 26;

  localparam logic [CfgIdxW-1:0] CfgMaxGap    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWeekSpan  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMonthSpan = 2'd2;

  localparam logic [GapW-1:0]  MaxGapRst    = 26'd5000000;
  localparam logic [SpanW-1:0] WeekSpanRst  = 6'd7;
  localparam logic [SpanW-1:0] MonthSpanRst = 6'd30;

  localparam logic [SlotEW-1:0] SlotEMax = {SlotEW{1'b1}};
  localparam logic [EnW-1:0]    EnMax    = {EnW{1'b1}};

  // Command travelling along the cell row.
  typedef enum logic [1:0] {
    OpNone  = 2'd0,
    OpClear = 2'd1,
    OpScan  = 2'd2,
    OpWrite = 2'd3
  } op_e;

  // Token passed from one cell to the next.
  typedef struct packed {
    op_e              op;
    logic [DayW-1:0]  day;
    logic [SpanW-1:0] week_span;
    logic [SpanW-1:0] month_span;
    logic             found;
    logic             have_free;
    logic             have_old;
    logic [DayW-1:0]  old_day;
    logic [8:0]       pick;     // chosen slot index (match, free or oldest)
    logic [8:0]       free_slot;
    logic [8:0]       old_idx;
    logic [EnW-1:0]   add_e;    // energy to add on write
    logic [EnW-1:0]   today;
    logic [EnW-1:0]   week;
    logic [EnW-1:0]   month;
  } tok_t;

  function automatic logic [EnW-1:0] sat63(input logic [EnW-1:0] a,
                                           input logic [EnW-1:0] b);
    logic [EnW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat63 = s[EnW] ? EnMax : s[EnW-1:0];
  endfunction

endpackage

### rtl/day_bucket_energy_accumulator.sv
// ----------------------------------------------------------------------------
// Day bucket energy accumulator
// Each transfer makes one scan pass and one write/sum pass of a token through
// the row of slot cells. A new input is taken only once the last item is
// through and its result has been taken by the receiver. Reset is
// asynchronous, active low, and empties all slots and counters at once.
// ----------------------------------------------------------------------------
module day_bucket_energy_accumulator import dbea_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // cmd, timestamp_us, relay_on_a, relay_on_b, watts_a, watts_b,
  // day_known, day_index, zero fill
  input  logic [127:0]        s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // total_energy, today_energy, week_energy, month_energy, zero fill
  output logic [255:0]        m_axis_tdata_o
);

  typedef enum logic [2:0] {
    StIdle, StMul, StScan, StWrite, StOut
  } state_e;

  state_e            state_q;
  logic [GapW-1:0]   max_gap_q;
  logic [SpanW-1:0]  week_q, month_q;
  logic [TsW-1:0]    last_q;
  logic              base_q;
  logic [EnW-1:0]    life_q, pend_q, add_q;
  logic              known_q, doslot_q;
  logic [DayW-1:0]   day_q;
  logic [8:0]        cnt_q;
  logic [GapW-1:0]   dt_q;
  logic [15:0]       wa_q, wb_q;
  logic              outv_q;
  logic [EnW-1:0]    o_tot_q, o_day_q, o_wk_q, o_mo_q;

  tok_t              inj_q, inj_d;
  tok_t              chain [SLOT_COUNT+1];
  logic [8:0]        pick_w;

  logic              in_cmd, in_a, in_b, in_known;
  logic [TsW-1:0]    in_ts;
  logic [15:0]       in_wa, in_wb;
  logic [DayW-1:0]   in_day;
  logic [TsW-1:0]    gap;
  logic [EnW-1:0]    e_sum;

  assign in_cmd   = s_axis_tdata_i[0];
  assign in_ts    = s_axis_tdata_i[63:1];
  assign in_a     = s_axis_tdata_i[64];
  assign in_b     = s_axis_tdata_i[65];
  assign in_wa    = s_axis_tdata_i[81:66];
  assign in_wb    = s_axis_tdata_i[97:82];
  assign in_known = s_axis_tdata_i[98];
  assign in_day   = s_axis_tdata_i[122:99];

  assign gap   = in_ts - last_q;
  assign e_sum = EnW'({16'd0, wa_q} * {16'd0, dt_q}) + EnW'({16'd0, wb_q} * {16'd0, dt_q});

  assign s_axis_tready_o = (state_q == StIdle) && !outv_q;
  assign m_axis_tvalid_o = outv_q;
  assign m_axis_tdata_o  = {4'd0, o_mo_q, o_wk_q, o_day_q, o_tot_q};

  assign chain[0] = inj_q;
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    dbea_cell #(.Idx(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  always_comb begin
    pick_w = chain[SLOT_COUNT].found ? chain[SLOT_COUNT].pick :
             chain[SLOT_COUNT].have_free ? chain[SLOT_COUNT].free_slot :
             chain[SLOT_COUNT].have_old ? chain[SLOT_COUNT].old_idx : 9'd0;
  end

  always_comb begin
    inj_d    = inj_q;
    inj_d.op = OpNone;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i && s_axis_tready_o && in_cmd) begin
          inj_d    = '0;
          inj_d.op = OpClear;
        end
      end
      StMul: begin
        inj_d     = '0;
        inj_d.op  = OpScan;
        inj_d.day = day_q;
      end
      StScan: begin
        if (cnt_q == 9'(SLOT_COUNT)) begin
          inj_d            = chain[SLOT_COUNT];
          inj_d.op         = OpWrite;
          inj_d.pick       = doslot_q ? pick_w : 9'h1FF;
          inj_d.add_e      = add_q;
          inj_d.week_span  = known_q ? week_q : '0;
          inj_d.month_span = known_q ? month_q : '0;
          inj_d.day        = known_q ? day_q : '0;
          inj_d.today      = '0;
          inj_d.week       = '0;
          inj_d.month      = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      max_gap_q <= MaxGapRst;
      week_q    <= WeekSpanRst;
      month_q   <= MonthSpanRst;
      last_q    <= '0;
      base_q    <= 1'b0;
      life_q    <= '0;
      pend_q    <= '0;
      add_q     <= '0;
      known_q   <= 1'b0;
      doslot_q  <= 1'b0;
      day_q     <= '0;
      dt_q      <= '0;
      wa_q      <= '0;
      wb_q      <= '0;
      outv_q    <= 1'b0;
      o_tot_q   <= '0;
      o_day_q   <= '0;
      o_wk_q    <= '0;
      o_mo_q    <= '0;
      inj_q     <= '0;
      cnt_q     <= '0;
    end else begin
      inj_q <= inj_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMaxGap:    max_gap_q <= cfg_data_i;
          CfgWeekSpan:  week_q    <= cfg_data_i[SpanW-1:0];
          CfgMonthSpan: month_q   <= cfg_data_i[SpanW-1:0];
          default: ;
        endcase
      end
      if (outv_q && m_axis_tready_i) outv_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            known_q <= in_known;
            day_q   <= in_day;
            wa_q    <= in_a ? in_wa : '0;
            wb_q    <= in_b ? in_wb : '0;
            if (in_cmd) begin
              life_q <= '0;
              pend_q <= '0;
              dt_q   <= '0;
            end else if (!base_q || in_ts <= last_q) begin
              base_q <= 1'b1;
              last_q <= in_ts;
              dt_q   <= '0;
            end else begin
              last_q <= in_ts;
              dt_q   <= (gap > {37'd0, max_gap_q}) ? max_gap_q : gap[GapW-1:0];
            end
            state_q <= StMul;
          end
        end
        StMul: begin
          if (e_sum != '0) begin
            life_q <= sat63(life_q, e_sum);
            if (!known_q) begin
              pend_q   <= sat63(pend_q, e_sum);
              doslot_q <= 1'b0;
              add_q    <= '0;
            end else begin
              doslot_q <= 1'b1;
              add_q    <= sat63(e_sum, pend_q);
              pend_q   <= '0;
            end
          end else begin
            doslot_q <= 1'b0;
            add_q    <= '0;
          end
          cnt_q <= '0;
          state_q <= StScan;
        end
        StScan: begin
          if (cnt_q == 9'(SLOT_COUNT)) begin
            cnt_q <= '0;
            state_q <= StWrite;
          end else begin
            cnt_q <= cnt_q + 9'd1;
          end
        end
        StWrite: begin
          if (cnt_q == 9'(SLOT_COUNT)) begin
            o_tot_q <= life_q;
            o_day_q <= known_q ? chain[SLOT_COUNT].today : '0;
            o_wk_q  <= known_q ? chain[SLOT_COUNT].week : '0;
            o_mo_q  <= known_q ? chain[SLOT_COUNT].month : '0;
            state_q <= StOut;
          end else begin
            cnt_q <= cnt_q + 9'd1;
          end
        end
        StOut: begin
          if (!outv_q) begin
            outv_q  <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> !s_axis_tready_o)
    else $error("input taken mid item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !outv_q) |=> outv_q)
    else $error("result not posted");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result dropped or changed while waiting");

endmodule

### rtl/dbea_cell.sv
// ----------------------------------------------------------------------------
// Day bucket energy accumulator slot cell
// Holds one day slot; scans, writes, sums and clears as the token passes.
// ----------------------------------------------------------------------------
module dbea_cell import dbea_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic              valid_q, valid_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [SlotEW-1:0] en_q, en_d;
  tok_t              tok_q, tok_d;
  logic [8:0]        idx;
  logic [EnW-1:0]    s1;

  assign idx = 9'(Idx);

  always_comb begin
    valid_d = valid_q;
    day_d   = day_q;
    en_d    = en_q;
    tok_d   = tok_i;
    s1 = '0;
    case (tok_i.op)
      OpClear: begin
        valid_d = 1'b0;
        day_d   = '0;
        en_d    = '0;
      end
      OpScan: begin
        if (valid_q) begin
          if (day_q == tok_i.day && !tok_i.found) begin
            tok_d.found = 1'b1;
            tok_d.pick  = idx;
          end
          if (!tok_i.have_old || day_q < tok_i.old_day) begin
            tok_d.have_old = 1'b1;
            tok_d.old_day  = day_q;
            tok_d.old_idx  = idx;
          end
        end else if (!tok_i.have_free) begin
          tok_d.have_free = 1'b1;
          tok_d.free_slot = idx;
        end
      end
      OpWrite: begin
        if (tok_i.pick == idx) begin
          s1 = sat63((tok_i.found ? {9'd0, en_q} : '0), tok_i.add_e);
          valid_d = 1'b1;
          day_d   = tok_i.day;
          en_d    = (s1 > {9'd0, SlotEMax}) ? SlotEMax : s1[SlotEW-1:0];
        end
        if ((tok_i.pick == idx ? 1'b1 : valid_q) && day_d <= tok_i.day) begin
          if (tok_i.day - day_d == '0)
            tok_d.today = sat63(tok_i.today, {9'd0, en_d});
          if ((tok_i.day - day_d) < {18'd0, tok_i.week_span})
            tok_d.week = sat63(tok_i.week, {9'd0, en_d});
          if ((tok_i.day - day_d) < {18'd0, tok_i.month_span})
            tok_d.month = sat63(tok_i.month, {9'd0, en_d});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      day_q   <= '0;
      en_q    <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      day_q   <= day_d;
      en_q    <= en_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Day bucket energy accumulator testbench
// Streams directed and random ticks through the block over several register
// settings. A local predictor keeps its own copy of the slot store and
// queues the expected sums. The monitor compares each result transfer with
// the oldest expected one. Both sides idle at random in some phases, and the
// receiver holds off twice for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import dbea_pkg::*;

  localparam int unsigned NSlot = SlotCountDef;
  localparam logic [63:0] Lim63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Lim54 = 64'h003F_FFFF_FFFF_FFFF;
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef struct {
    logic            cmd;
    logic [TsW-1:0]  ts;
    logic            on_a;
    logic            on_b;
    logic [15:0]     w_a;
    logic [15:0]     w_b;
    logic            known;
    logic [DayW-1:0] day;
  } tick_t;

  typedef struct {
    logic [EnW-1:0] total;
    logic [EnW-1:0] today;
    logic [EnW-1:0] week;
    logic [EnW-1:0] month;
  } sums_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [127:0]        s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [255:0]        m_axis_tdata_o;

  day_bucket_energy_accumulator dut (.*);

  tick_t tick_q[$];
  sums_t sums_q[$];
  int    errors = 0;

  // predictor state
  logic [63:0]     p_gap = 64'(MaxGapRst);
  logic [5:0]      p_week = WeekSpanRst;
  logic [5:0]      p_month = MonthSpanRst;
  logic [63:0]     p_last = '0;
  logic            p_base = 1'b0;
  logic            p_valid[NSlot];
  logic [DayW-1:0] p_day[NSlot];
  logic [63:0]     p_energy[NSlot];
  logic [63:0]     p_life = '0;
  logic [63:0]     p_pend = '0;

  logic idle_on = 1'b1;
  logic stall_go = 1'b0;
  int   send_gap = 0;
  int   recv_hold = 0;
  int   long_cnt = 0;

  logic [TsW-1:0]  ts_cur = '0;
  logic [DayW-1:0] day_cur = 24'd19000;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] lim);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, lim}) ? lim : s[63:0];
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < NSlot; i++) begin
      p_valid[i] = 1'b0;
      p_day[i] = '0;
      p_energy[i] = '0;
    end
    p_life = '0;
    p_pend = '0;
  endfunction

  function automatic int pick_slot(logic [DayW-1:0] day);
    int fr;
    int old;
    int k;
    fr = -1;
    old = -1;
    for (int i = 0; i < NSlot; i++) begin
      if (p_valid[i]) begin
        if (p_day[i] == day) return i;
        if (old < 0 || p_day[i] < p_day[old]) old = i;
      end else if (fr < 0) begin
        fr = i;
      end
    end
    k = (fr >= 0) ? fr : ((old >= 0) ? old : 0);
    p_valid[k] = 1'b1;
    p_day[k] = day;
    p_energy[k] = '0;
    return k;
  endfunction

  function automatic sums_t predict_sums(tick_t t);
    sums_t r;
    logic [63:0] dt;
    logic [63:0] e;
    logic [63:0] td;
    logic [63:0] wk;
    logic [63:0] mo;
    logic [DayW-1:0] age;
    int k;
    if (t.cmd == CmdClear) begin
      clear_store();
    end else if (!p_base) begin
      p_base = 1'b1;
      p_last = 64'(t.ts);
    end else if (64'(t.ts) <= p_last) begin
      p_last = 64'(t.ts);
    end else begin
      dt = 64'(t.ts) - p_last;
      p_last = 64'(t.ts);
      if (dt > p_gap) dt = p_gap;
      e = '0;
      if (t.on_a) e = e + 64'(t.w_a) * dt;
      if (t.on_b) e = e + 64'(t.w_b) * dt;
      if (e != 0) begin
        p_life = sat_sum(p_life, e, Lim63);
        if (!t.known) begin
          p_pend = sat_sum(p_pend, e, Lim63);
        end else begin
          k = pick_slot(t.day);
          p_energy[k] = sat_sum(sat_sum(p_energy[k], e, Lim63), p_pend, Lim54);
          p_pend = '0;
        end
      end
    end
    td = '0;
    wk = '0;
    mo = '0;
    if (t.known) begin
      for (int i = 0; i < NSlot; i++) begin
        if (p_valid[i] && p_day[i] <= t.day) begin
          age = t.day - p_day[i];
          if (age == 0) td = sat_sum(td, p_energy[i], Lim63);
          if (age < p_week) wk = sat_sum(wk, p_energy[i], Lim63);
          if (age < p_month) mo = sat_sum(mo, p_energy[i], Lim63);
        end
      end
    end
    r.total = p_life[EnW-1:0];
    r.today = td[EnW-1:0];
    r.week = wk[EnW-1:0];
    r.month = mo[EnW-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      sums_q.push_back(predict_sums(tick_t'{
        cmd: s_axis_tdata_i[0], ts: s_axis_tdata_i[63:1], on_a: s_axis_tdata_i[64],
        on_b: s_axis_tdata_i[65], w_a: s_axis_tdata_i[81:66],
        w_b: s_axis_tdata_i[97:82], known: s_axis_tdata_i[98],
        day: s_axis_tdata_i[122:99]}));
    end
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (tick_q.size() > 0) begin
        tick_t t;
        t = tick_q.pop_front();
        s_axis_tdata_i <= {5'b0, t.day, t.known, t.w_b, t.w_a, t.on_b, t.on_a,
                           t.ts, t.cmd};
        s_axis_tvalid_i <= 1'b1;
        send_gap <= idle_on ? $urandom_range(0, 5) : 0;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (long_cnt > 0) long_cnt <= long_cnt - 1;
    else if (stall_go) long_cnt <= 400;
  end

  // monitor
  always @(posedge clk_i) begin
    sums_t exp_s;
    sums_t got;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.total = m_axis_tdata_o[62:0];
      got.today = m_axis_tdata_o[125:63];
      got.week = m_axis_tdata_o[188:126];
      got.month = m_axis_tdata_o[251:189];
      if (sums_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer total=%0d", got.total);
      end else begin
        exp_s = sums_q.pop_front();
        if (exp_s.total != got.total || exp_s.today != got.today ||
            exp_s.week != got.week || exp_s.month != got.month) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     exp_s.total, exp_s.today, exp_s.week, exp_s.month,
                     got.total, got.today, got.week, got.month);
        end
      end
      recv_hold <= idle_on ? $urandom_range(0, 5) : 0;
      m_axis_tready_i <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rst_ni && (long_cnt == 0);
    end
  end

  task automatic add_tick(logic cmd, logic [TsW-1:0] ts, logic on_a, logic on_b,
                          logic [15:0] w_a, logic [15:0] w_b, logic known,
                          logic [DayW-1:0] day);
    tick_q.push_back(tick_t'{cmd: cmd, ts: ts, on_a: on_a, on_b: on_b, w_a: w_a,
                             w_b: w_b, known: known, day: day});
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgMaxGap:    p_gap = 64'(val);
      CfgWeekSpan:  p_week = val[5:0];
      CfgMonthSpan: p_month = val[5:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [CfgDataW-1:0] gap, logic [5:0] wk, logic [5:0] mo);
    write_reg(CfgMaxGap, gap);
    write_reg(CfgWeekSpan, 26'(wk));
    write_reg(CfgMonthSpan, 26'(mo));
  endtask

  task automatic wait_drain();
    wait (tick_q.size() == 0 && !s_axis_tvalid_i && sums_q.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic add_random(int n);
    logic [TsW-1:0] ts;
    logic [DayW-1:0] dy;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) ts_cur = TsW'({$urandom(), $urandom()});
      else if (r < 8) ts_cur = ts_cur - TsW'($urandom_range(0, 3000000));
      else ts_cur = ts_cur + TsW'($urandom_range(0, 8000000));
      r = $urandom_range(0, 99);
      if (r < 3) day_cur = 24'($urandom());
      else if (r < 25) day_cur = day_cur + 24'($urandom_range(1, 3));
      dy = day_cur;
      if ($urandom_range(0, 19) == 0) dy = day_cur - 24'($urandom_range(1, 40));
      ts = ts_cur;
      add_tick(($urandom_range(0, 99) == 0) ? CmdClear : CmdTick, ts,
               1'($urandom()), 1'($urandom()), 16'($urandom()), 16'($urandom()),
               $urandom_range(0, 9) != 0, dy);
    end
  endtask

  initial begin
    clear_store();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    add_tick(CmdTick, 63'd1000, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 24'd100);
    add_tick(CmdTick, 63'd2000000, 1'b1, 1'b0, 16'd500, 16'd7, 1'b1, 24'd100);
    add_tick(CmdTick, 63'd2000000, 1'b1, 1'b1, 16'd500, 16'd7, 1'b1, 24'd100);
    add_tick(CmdTick, 63'd1500000, 1'b1, 1'b1, 16'd500, 16'd7, 1'b1, 24'd100);
    add_tick(CmdTick, 63'd3000000, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 24'd100);
    add_tick(CmdTick, 63'd4000000, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 24'd100);
    add_tick(CmdTick, 63'd90000000, 1'b0, 1'b1, 16'd1, 16'hFFFF, 1'b0, 24'd0);
    add_tick(CmdTick, 63'd91000000, 1'b1, 1'b1, 16'd3, 16'd4, 1'b0, 24'hFFFFFF);
    add_tick(CmdTick, 63'd92000000, 1'b1, 1'b0, 16'd9, 16'd0, 1'b1, 24'd101);
    add_tick(CmdTick, 63'd93000000, 1'b1, 1'b0, 16'd9, 16'd0, 1'b1, 24'd99);
    add_tick(CmdTick, 63'd94000000, 1'b1, 1'b0, 16'd9, 16'd0, 1'b1, 24'd110);
    add_tick(CmdTick, 63'd95000000, 1'b1, 1'b1, 16'd2, 16'd2, 1'b1, 24'd98);
    add_tick(CmdClear, 63'd0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 24'd110);
    add_tick(CmdTick, 63'd96000000, 1'b1, 1'b1, 16'd5, 16'd5, 1'b1, 24'd0);
    add_tick(CmdTick, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF,
             1'b1, 24'hFFFFFF);
    add_tick(CmdTick, 63'd5, 1'b1, 1'b1, 16'd1, 16'd1, 1'b1, 24'd0);
    for (int d = 0; d < 34; d += 5)
      add_tick(CmdTick, 63'(97000000 + d * 1000), 1'b1, 1'b0, 16'd1, 16'd0, 1'b1,
               24'(200 + d));
    stall_go <= 1'b1;
    @(posedge clk_i);
    stall_go <= 1'b0;
    wait_drain();

    ts_cur = 63'd200000000;
    set_regs(26'd60000000, 6'd32, 6'd32);
    idle_on = 1'b0;
    add_random(220);
    @(posedge clk_i);
    stall_go <= 1'b1;
    @(posedge clk_i);
    stall_go <= 1'b0;
    wait_drain();

    set_regs(26'd1, 6'd1, 6'd1);
    idle_on = 1'b1;
    add_random(200);
    wait_drain();

    set_regs(26'h3FFFFFF, 6'd0, 6'd63);
    add_random(200);
    wait_drain();

    set_regs(26'd0, 6'd63, 6'd0);
    add_random(40);
    wait_drain();

    set_regs(MaxGapRst, WeekSpanRst, MonthSpanRst);
    add_random(240);
    wait_drain();

    set_regs(26'd3000000, 6'd3, 6'd12);
    idle_on = 1'b0;
    add_random(200);
    wait_drain();

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("testbench: errors");
    $finish;
  end
endmodule
